>>> design/susi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// susi_pkg
// Shared types and constants for the sorted unique identifier set.
// ----------------------------------------------------------------------------
package susi_pkg;

  localparam int ID_W         = 32;
  localparam int CNT_OUT_W    = 7;
  localparam int DEF_CAPACITY = 64;

  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic            op;
    logic [ID_W-1:0] ident;
  } susi_in_t;

  typedef struct packed {
    logic                 present;
    logic                 inserted;
    logic                 full_res;
    logic [CNT_OUT_W-1:0] count;
  } susi_out_t;

  // what one cell hands to its upper neighbor
  typedef struct packed {
    logic            gt;
    logic [ID_W-1:0] entry;
  } susi_link_t;

  localparam susi_link_t LINK_NONE = '{gt: 1'b0, entry: '0};

endpackage
`default_nettype wire

>>> design/susi_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// susi_cell
// One slot of the sorted set: compares its entry with the broadcast key and,
// on an insert, loads either the key or its lower neighbor's entry.
// ----------------------------------------------------------------------------
module susi_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  wire logic                     clk,
  input  wire logic [susi_pkg::ID_W-1:0] key,
  input  wire logic [CW-1:0]            count,
  input  wire logic                     ins_en,
  input  wire susi_pkg::susi_link_t     link_in,
  output susi_pkg::susi_link_t          link_out,
  output logic                          eq
);
  import susi_pkg::*;

  logic [ID_W-1:0] entry_r;
  logic [ID_W-1:0] entry_nxt;
  logic            valid;
  logic            gt;
  logic            load;

  assign valid = (count > CW'(IDX));
  assign gt    = valid && (entry_r > key);
  assign eq    = valid && (entry_r == key);
  // slots above the insertion point shift up; the first slot not below key takes key
  assign load  = ins_en && (gt || !valid);

  always_comb begin
    entry_nxt = entry_r;
    if (load) begin
      entry_nxt = link_in.gt ? link_in.entry : key;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign link_out.gt    = gt;
  assign link_out.entry = entry_r;

endmodule
`default_nettype wire

>>> design/sorted_unique_id_set_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_unique_id_set_unit
// Holds up to CAPACITY distinct 32-bit identifiers in ascending order in a
// row of cells, one identifier per cell. Each input beat is a membership
// query or an insert-if-missing and yields one result beat. The key is
// broadcast to every cell, all cells compare in parallel, and an insert
// shifts the larger entries up one cell in the same cycle, so the unit takes
// one beat per clock unless a held result stalls it; a beat's result is
// registered and appears on the next cycle. The key compare in each cell plus
// the OR of all cell hits bound that cycle. No clearing pass after reset:
// only count and out_valid are reset; cells at or above count are ignored.
// ----------------------------------------------------------------------------
module sorted_unique_id_set_unit #(
  parameter int CAPACITY = susi_pkg::DEF_CAPACITY
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire susi_pkg::susi_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output susi_pkg::susi_out_t      out_data
);
  import susi_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  susi_out_t           out_data_r;
  susi_out_t           out_data_nxt;
  logic                in_fire;
  logic                hit;
  logic                full;
  logic                ins_en;
  logic [CAPACITY-1:0] eq_vec;
  susi_link_t          link [CAPACITY];

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign hit      = |eq_vec;
  assign full     = (count_r == CW'(CAPACITY));
  assign ins_en   = in_fire && (in_data.op == OP_INSERT) && !hit && !full;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    susi_link_t lnk_in;
    if (i == 0) begin : g_first
      assign lnk_in = LINK_NONE;
    end else begin : g_rest
      assign lnk_in = link[i-1];
    end
    susi_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .key      (in_data.ident),
      .count    (count_r),
      .ins_en   (ins_en),
      .link_in  (lnk_in),
      .link_out (link[i]),
      .eq       (eq_vec[i])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ins_en) begin
      count_nxt = count_r + CW'(1);
    end
    if (in_fire) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.present  = hit;
      out_data_nxt.inserted = ins_en;
      out_data_nxt.full_res = (in_data.op == OP_INSERT) && !hit && full;
      out_data_nxt.count    = CNT_OUT_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_res_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.inserted && (out_data_r.present || out_data_r.full_res)))
    else $error("inserted result also flagged present or full");

  a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.full_res |-> count_r == CW'(CAPACITY))
    else $error("insert refused while set not full");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    ins_en |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not advance count");
`endif

endmodule
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_unique_id_set_unit. A directed table covers
// the empty set, the extreme identifiers, duplicate inserts and inserts at
// the low and high ends. Random traffic then fills the set slowly, mostly
// hitting held identifiers and their neighbors, and goes on to hammer the
// full set. Each result beat is checked against the table on chk rows, else
// a queue-based set model. Both channels idle at random, with idle-free bursts.
// ----------------------------------------------------------------------------
module tb;
  import susi_pkg::*;

  localparam int SET_CAP    = DEF_CAPACITY;
  localparam int RAND_ITEMS = 1680;
  localparam int FILL_ITEMS = 1000;

  typedef struct {
    bit        chk;
    susi_in_t  beat;
    susi_out_t res;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  susi_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  susi_out_t out_data;

  logic [ID_W-1:0] held_ids[$];
  susi_out_t       pending_results[$];
  dir_row_t        dir_rows[$];
  int              mismatch_cnt = 0;
  bit              burst = 1'b0;

  sorted_unique_id_set_unit #(.CAPACITY(SET_CAP)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // model of the set: lookup, insert at sorted slot, refuse when full
  function automatic susi_out_t predict_set_result(susi_in_t beat);
    susi_out_t r;
    int        pos;
    bit        found;
    pos   = held_ids.size();
    found = 1'b0;
    r     = '0;
    for (int i = 0; i < held_ids.size(); i++) begin
      if (!found && held_ids[i] >= beat.ident) begin
        found = 1'b1;
        pos   = i;
        r.present = (held_ids[i] == beat.ident);
      end
    end
    if (beat.op == OP_INSERT && !r.present) begin
      if (held_ids.size() >= SET_CAP) begin
        r.full_res = 1'b1;
      end else begin
        held_ids.insert(pos, beat.ident);
        r.inserted = 1'b1;
      end
    end
    r.count = CNT_OUT_W'(held_ids.size());
    return r;
  endfunction

  function automatic logic [ID_W-1:0] pick_ident();
    int sel;
    int n;
    n   = held_ids.size();
    sel = $urandom_range(0, 9);
    if (n > 0 && sel <= 3) return held_ids[$urandom_range(0, n - 1)];
    if (n > 0 && sel == 4) return held_ids[$urandom_range(0, n - 1)] + 1;
    if (n > 0 && sel == 5) return held_ids[$urandom_range(0, n - 1)] - 1;
    if (sel == 6) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return '1;
        2: return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  task automatic add_row(bit chk, logic op, logic [ID_W-1:0] id,
                         logic p, logic ins, logic f, int c);
    dir_row_t row;
    row.chk        = chk;
    row.beat.op    = op;
    row.beat.ident = id;
    row.res.present  = p;
    row.res.inserted = ins;
    row.res.full_res = f;
    row.res.count    = CNT_OUT_W'(c);
    dir_rows.push_back(row);
  endtask

  task automatic flag_mismatch(string what, int got, int want);
    $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic send_beat(susi_in_t beat, bit chk, susi_out_t typed);
    int        gap;
    susi_out_t want;
    gap = burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    want = predict_set_result(beat);
    if (chk) want = typed;
    pending_results.push_back(want);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result beat", 1, 0);
      end else begin
        susi_out_t want;
        want = pending_results.pop_front();
        if (out_data.present !== want.present)
          flag_mismatch("present", out_data.present, want.present);
        if (out_data.inserted !== want.inserted)
          flag_mismatch("inserted", out_data.inserted, want.inserted);
        if (out_data.full_res !== want.full_res)
          flag_mismatch("full_res", out_data.full_res, want.full_res);
        if (out_data.count !== want.count)
          flag_mismatch("count", out_data.count, want.count);
      end
    end
  end

  // result side: random stall before each beat
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    susi_in_t  beat;
    susi_out_t none;
    none = '0;

    add_row(1, OP_QUERY,  32'h0000_0000, 0, 0, 0, 0);
    add_row(1, OP_QUERY,  32'hFFFF_FFFF, 0, 0, 0, 0);
    add_row(1, OP_INSERT, 32'h8000_0000, 0, 1, 0, 1);
    add_row(1, OP_INSERT, 32'h8000_0000, 1, 0, 0, 1);
    add_row(1, OP_QUERY,  32'h8000_0000, 1, 0, 0, 1);
    add_row(1, OP_INSERT, 32'h0000_0000, 0, 1, 0, 2);
    add_row(1, OP_INSERT, 32'hFFFF_FFFF, 0, 1, 0, 3);
    add_row(1, OP_QUERY,  32'h0000_0000, 1, 0, 0, 3);
    add_row(1, OP_QUERY,  32'hFFFF_FFFF, 1, 0, 0, 3);
    add_row(0, OP_INSERT, 32'h7FFF_FFFF, 0, 0, 0, 0);
    add_row(0, OP_INSERT, 32'h8000_0001, 0, 0, 0, 0);
    add_row(0, OP_QUERY,  32'h7FFF_FFFE, 0, 0, 0, 0);
    add_row(0, OP_QUERY,  32'h8000_0001, 0, 0, 0, 0);
    add_row(0, OP_INSERT, 32'h0000_0000, 0, 0, 0, 0);
    add_row(0, OP_INSERT, 32'h5555_5555, 0, 0, 0, 0);
    add_row(0, OP_INSERT, 32'hAAAA_AAAA, 0, 0, 0, 0);
    add_row(0, OP_QUERY,  32'h0000_0001, 0, 0, 0, 0);
    add_row(0, OP_INSERT, 32'h0000_0001, 0, 0, 0, 0);
    add_row(0, OP_INSERT, 32'hFFFF_FFFE, 0, 0, 0, 0);
    add_row(0, OP_QUERY,  32'hFFFF_FFFE, 0, 0, 0, 0);
    add_row(0, OP_QUERY,  32'h5555_5554, 0, 0, 0, 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].chk, dir_rows[i].res);
    drain_results();

    // slow fill with mostly lookups, then a long stretch on the full set
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      if (k == 850) drain_results();
      if (k < FILL_ITEMS)
        beat.op = ($urandom_range(0, 7) == 0) ? OP_INSERT : OP_QUERY;
      else
        beat.op = $urandom_range(0, 1) ? OP_INSERT : OP_QUERY;
      beat.ident = pick_ident();
      send_beat(beat, 1'b0, none);
    end
    in_valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
